### hdl/wlss_pkg.sv
`timescale 1ns / 1ps

package wlss_pkg;

    localparam int SLOTS    = 100;
    localparam int SLOT_W   = $clog2(SLOTS);
    localparam int NUM_W    = 14;
    localparam int MAX_W    = 15;
    localparam int IN_W     = 32;
    localparam int OUT_W    = 48;

    // Sequence number rules
    localparam logic signed [MAX_W-1:0] NUM_NONE   = -15'sd1;
    localparam logic signed [MAX_W-1:0] HALF_RANGE = 15'sd5000;
    localparam logic signed [MAX_W-1:0] WRAP_HIGH  = 15'sd8000;
    localparam logic signed [MAX_W-1:0] WRAP_LOW   = 15'sd2000;
    localparam logic signed [MAX_W-1:0] NUM_TOP    = 15'sd9999;
    localparam logic [NUM_W-1:0]        NUM_MOD    = 14'd10000;
    localparam logic [MAX_W-1:0]        NUM_MOD_W  = 15'd10000;

    typedef enum logic [1:0] {
        REQ_BEGIN  = 2'd0,
        REQ_REPORT = 2'd1,
        REQ_ALLOC  = 2'd2,
        REQ_NONE   = 2'd3
    } req_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FREE,
        ST_OLD,
        ST_COMMIT
    } state_t;

    // Input tdata layout, lowest field in the lowest bits
    typedef struct packed {
        logic [6:0]       pad;
        logic             has_changes;
        logic             copies_agree;
        logic             checksum_ok;
        logic [NUM_W-1:0] seq_number;
        logic             seq_present;
        logic [6:0]       slot_index;
    } in_t;

    // Output tdata layout, lowest field in the lowest bits
    typedef struct packed {
        logic [1:0]              pad;
        logic                    checksum_problem;
        logic                    current_valid;
        logic [6:0]              current_slot;
        logic signed [MAX_W-1:0] max_number;
        logic                    write_done;
        logic [NUM_W-1:0]        new_number;
        logic [6:0]              chosen_slot;
    } res_t;

    // Write request into the slot table
    typedef struct packed {
        logic              en;
        logic [SLOT_W-1:0] idx;
        logic [NUM_W-1:0]  num;
        logic              vld;
    } tbl_wr_t;

endpackage

### hdl/wlss_slot_table.sv
`timescale 1ns / 1ps

module wlss_slot_table (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  wlss_pkg::tbl_wr_t         wr,
    input  logic [wlss_pkg::SLOT_W-1:0] rd_idx,
    output logic [wlss_pkg::NUM_W-1:0]  rd_num,
    output logic                      rd_vld
);
    import wlss_pkg::*;

    logic [NUM_W-1:0]  mem_array [SLOTS];
    logic [SLOTS-1:0]  vld_reg;
    logic [NUM_W-1:0]  rd_num_reg;
    logic              rd_vld_reg;

    // number storage, one write and one registered read per cycle
    always_ff @(posedge aclk) begin
        if (wr.en) begin
            mem_array[wr.idx] <= wr.num;
        end
        rd_num_reg <= mem_array[rd_idx];
    end

    // per-slot used bits; an unused slot reads as -1 upstream
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg    <= '0;
            rd_vld_reg <= 1'b0;
        end else begin
            if (wr.en) begin
                vld_reg[wr.idx] <= wr.vld;
            end
            rd_vld_reg <= vld_reg[rd_idx];
        end
    end

    assign rd_num = rd_num_reg;
    assign rd_vld = rd_vld_reg;

endmodule

### hdl/wear_level_slot_selector.sv
`timescale 1ns / 1ps

// Save-slot selector for wear-levelled flash saves.
// Input stream (s_*): one request per transfer; s_tuser carries the request
// kind (begin scan, scanned slot report, allocate), s_tdata the slot report
// fields and the has-changes flag. Result stream (m_*): exactly one result
// per request: chosen slot, new number, write-done flag and the status
// (newest number, current slot and its valid flag, sticky checksum problem).
// For begin scan, report and unused codes the result sits in the output
// register on the cycle after the transfer.
// Allocate walks the slot table through its single read port: one pass for
// the free slot and the newest number, a second pass for the oldest slot
// when none is free, then a commit step that issues the result.
// One request is in flight at a time; s_tready drops while allocate runs.
// Reset: all slots read unused, newest number -1, status cleared; the used
// bits are flip-flops, so no clearing pass is needed.
// A stalled receiver holds the result in the output register; a new request
// is taken only when that register is empty or being drained.
module wear_level_slot_selector (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // [6:0] slot_index, [7] seq_present, [21:8] seq_number, [22] checksum_ok,
    // [23] copies_agree, [24] has_changes, [31:25] zero
    input  logic [31:0] s_tdata,
    // [1:0] req_type
    input  logic [1:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // [6:0] chosen_slot, [20:7] new_number, [21] write_done,
    // [36:22] max_number, [43:37] current_slot, [44] current_valid,
    // [45] checksum_problem, [47:46] zero
    output logic [47:0] m_tdata
);
    import wlss_pkg::*;

    state_t                  state_reg, state_next;

    // block status
    logic signed [MAX_W-1:0] newest_reg, newest_next;
    logic [SLOT_W-1:0]       cur_slot_reg, cur_slot_next;
    logic                    cur_vld_reg, cur_vld_next;
    logic                    problem_reg, problem_next;

    // allocate sweep
    logic                    has_chg_reg, has_chg_next;
    logic [SLOT_W-1:0]       addr_reg, addr_next;
    logic                    issue_reg, issue_next;
    logic                    proc_reg, proc_next;
    logic [SLOT_W-1:0]       pidx_reg, pidx_next;
    logic                    free_found_reg, free_found_next;
    logic [SLOT_W-1:0]       free_idx_reg, free_idx_next;
    logic signed [MAX_W-1:0] high_reg, high_next;
    logic signed [MAX_W-1:0] low_reg, low_next;
    logic                    wrapped_reg, wrapped_next;
    logic [SLOT_W-1:0]       cand_reg, cand_next;
    logic [NUM_W-1:0]        cand_val_reg, cand_val_next;

    // output register
    logic                    m_tvalid_reg, m_tvalid_next;
    res_t                    m_res_reg, m_res_next;

    in_t                     s_in;
    req_t                    s_req;
    logic                    s_fire;
    logic                    out_free;
    logic                    last_data;
    logic                    free_now;
    tbl_wr_t                 tbl_wr;
    logic [NUM_W-1:0]        rd_num;
    logic                    rd_vld;

    assign s_in     = in_t'(s_tdata);
    assign s_req    = req_t'(s_tuser);
    assign out_free = !m_tvalid_reg || m_tready;
    assign s_tready = (state_reg == ST_IDLE) && out_free;
    assign s_fire   = s_tvalid && s_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_res_reg;

    assign last_data = proc_reg && (pidx_reg == SLOT_W'(SLOTS - 1));
    assign free_now  = free_found_reg || (proc_reg && !rd_vld);

    wlss_slot_table u_table (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr      (tbl_wr),
        .rd_idx  (addr_reg),
        .rd_num  (rd_num),
        .rd_vld  (rd_vld)
    );

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_fire && s_req == REQ_ALLOC) begin
                    state_next = ST_FREE;
                end
            end
            ST_FREE: begin
                if (last_data) begin
                    state_next = free_now ? ST_COMMIT : ST_OLD;
                end
            end
            ST_OLD: begin
                if (last_data) begin
                    state_next = ST_COMMIT;
                end
            end
            ST_COMMIT: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        logic                    in_rng;
        logic                    num_ok;
        logic                    n_ok;
        logic signed [MAX_W-1:0] n_s;
        logic signed [MAX_W-1:0] t1;
        logic signed [MAX_W-1:0] t2;
        logic signed [MAX_W-1:0] v_s;
        logic signed [MAX_W-1:0] hn;
        logic signed [MAX_W-1:0] ln;
        logic                    wr_n;
        logic [MAX_W-1:0]        floor_v;
        logic [MAX_W-1:0]        cv;
        logic [NUM_W-1:0]        nn;

        newest_next     = newest_reg;
        cur_slot_next   = cur_slot_reg;
        cur_vld_next    = cur_vld_reg;
        problem_next    = problem_reg;
        has_chg_next    = has_chg_reg;
        addr_next       = addr_reg;
        issue_next      = issue_reg;
        proc_next       = issue_reg;
        pidx_next       = addr_reg;
        free_found_next = free_found_reg;
        free_idx_next   = free_idx_reg;
        high_next       = high_reg;
        low_next        = low_reg;
        wrapped_next    = wrapped_reg;
        cand_next       = cand_reg;
        cand_val_next   = cand_val_reg;
        m_tvalid_next   = m_tvalid_reg && !m_tready;
        m_res_next      = m_res_reg;
        tbl_wr          = '0;

        in_rng  = 32'(s_in.slot_index) < SLOTS;
        num_ok  = s_in.seq_present && (s_in.seq_number < NUM_MOD);
        n_ok    = num_ok && s_in.checksum_ok;
        n_s     = $signed({1'b0, s_in.seq_number});
        t1      = newest_reg;
        t2      = newest_reg;
        v_s     = rd_vld ? $signed({1'b0, rd_num}) : NUM_NONE;
        hn      = high_reg;
        ln      = low_reg;
        wr_n    = 1'b0;
        floor_v = wrapped_reg ? MAX_W'(HALF_RANGE) : '0;
        cv      = (MAX_W'(cand_val_reg) < floor_v) ? MAX_W'(cand_val_reg) + NUM_MOD_W
                                                   : MAX_W'(cand_val_reg);
        nn      = (newest_reg < 15'sd1 || newest_reg >= NUM_TOP) ? NUM_W'(1)
                                                                : NUM_W'(newest_reg + 15'sd1);

        // sweep address generator
        if (issue_reg) begin
            addr_next = addr_reg + SLOT_W'(1);
            if (addr_reg == SLOT_W'(SLOTS - 1)) begin
                issue_next = 1'b0;
            end
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_fire) begin
                    case (s_req)
                        REQ_BEGIN: begin
                            newest_next   = NUM_NONE;
                            cur_slot_next = '0;
                            cur_vld_next  = 1'b0;
                            problem_next  = 1'b0;
                        end
                        REQ_REPORT: begin
                            if (in_rng) begin
                                if (!s_in.copies_agree || (num_ok && !s_in.checksum_ok)) begin
                                    problem_next = 1'b1;
                                end
                                tbl_wr.en  = 1'b1;
                                tbl_wr.idx = SLOT_W'(s_in.slot_index);
                                tbl_wr.num = s_in.seq_number;
                                tbl_wr.vld = n_ok;
                                if (n_ok) begin
                                    if (newest_reg < 15'sd0) begin
                                        t1 = n_s;
                                    end else if (newest_reg > WRAP_HIGH && n_s < WRAP_LOW) begin
                                        t1 = n_s;
                                    end
                                    t2 = t1;
                                    if (n_s > t1 && n_s < t1 + WRAP_LOW) begin
                                        t2 = n_s;
                                    end
                                    newest_next = t2;
                                    if (t2 == n_s) begin
                                        cur_slot_next = SLOT_W'(s_in.slot_index);
                                        cur_vld_next  = 1'b1;
                                    end
                                end
                            end
                        end
                        REQ_ALLOC: begin
                            has_chg_next    = s_in.has_changes;
                            addr_next       = '0;
                            issue_next      = 1'b1;
                            proc_next       = 1'b0;
                            free_found_next = 1'b0;
                            free_idx_next   = '0;
                            high_next       = NUM_NONE;
                            low_next        = NUM_NONE;
                        end
                        default: begin
                        end
                    endcase
                    if (s_req != REQ_ALLOC) begin
                        m_tvalid_next               = 1'b1;
                        m_res_next                  = '0;
                        m_res_next.max_number       = newest_next;
                        m_res_next.current_slot     = 7'(cur_slot_next);
                        m_res_next.current_valid    = cur_vld_next;
                        m_res_next.checksum_problem = problem_next;
                    end
                end
            end
            ST_FREE: begin
                if (proc_reg) begin
                    if (!rd_vld && !free_found_reg) begin
                        free_found_next = 1'b1;
                        free_idx_next   = pidx_reg;
                    end
                    if (v_s > HALF_RANGE) begin
                        if (v_s > high_reg) begin
                            hn = v_s;
                        end
                    end else if (v_s > low_reg) begin
                        ln = v_s;
                    end
                    high_next = hn;
                    low_next  = ln;
                end
                if (last_data) begin
                    wrapped_next = (hn > WRAP_HIGH) && (ln >= 15'sd0);
                    if (wrapped_next) begin
                        newest_next = ln;
                    end else begin
                        newest_next = (ln > hn) ? ln : hn;
                    end
                    cand_next     = free_now ? free_idx_next : '0;
                    cand_val_next = '0;
                    if (!free_now) begin
                        addr_next  = '0;
                        issue_next = 1'b1;
                    end
                end
            end
            ST_OLD: begin
                if (proc_reg) begin
                    if (pidx_reg == '0) begin
                        cand_val_next = rd_num;
                    end else if (MAX_W'(rd_num) > floor_v && MAX_W'(rd_num) < cv) begin
                        cand_next     = pidx_reg;
                        cand_val_next = rd_num;
                    end
                end
            end
            ST_COMMIT: begin
                if (out_free) begin
                    m_tvalid_next      = 1'b1;
                    m_res_next         = '0;
                    m_res_next.chosen_slot = 7'(cand_reg);
                    if (has_chg_reg) begin
                        wr_n                  = 1'b1;
                        newest_next           = $signed({1'b0, nn});
                        m_res_next.new_number = nn;
                        m_res_next.write_done = 1'b1;
                    end
                    tbl_wr.en  = wr_n;
                    tbl_wr.idx = cand_reg;
                    tbl_wr.num = nn;
                    tbl_wr.vld = 1'b1;
                    m_res_next.max_number       = newest_next;
                    m_res_next.current_slot     = 7'(cur_slot_reg);
                    m_res_next.current_valid    = cur_vld_reg;
                    m_res_next.checksum_problem = problem_reg;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            newest_reg     <= NUM_NONE;
            cur_slot_reg   <= '0;
            cur_vld_reg    <= 1'b0;
            problem_reg    <= 1'b0;
            issue_reg      <= 1'b0;
            proc_reg       <= 1'b0;
            free_found_reg <= 1'b0;
            m_tvalid_reg   <= 1'b0;
        end else begin
            state_reg      <= state_next;
            newest_reg     <= newest_next;
            cur_slot_reg   <= cur_slot_next;
            cur_vld_reg    <= cur_vld_next;
            problem_reg    <= problem_next;
            issue_reg      <= issue_next;
            proc_reg       <= proc_next;
            free_found_reg <= free_found_next;
            m_tvalid_reg   <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        has_chg_reg  <= has_chg_next;
        addr_reg     <= addr_next;
        pidx_reg     <= pidx_next;
        free_idx_reg <= free_idx_next;
        high_reg     <= high_next;
        low_reg      <= low_next;
        wrapped_reg  <= wrapped_next;
        cand_reg     <= cand_next;
        cand_val_reg <= cand_val_next;
        m_res_reg    <= m_res_next;
    end

    // an allocate request always starts the free-slot sweep
    a_alloc_start: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_fire && s_req == REQ_ALLOC) |=> state_reg == ST_FREE)
        else $error("allocate did not start the sweep");

    // begin scan, report and unused requests show their result on the next cycle
    a_quick_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_fire && s_req != REQ_ALLOC) |=> m_tvalid)
        else $error("missing result for single-cycle request");

    // table read data is only consumed inside a sweep
    a_proc_in_sweep: assert property (@(posedge aclk) disable iff (!aresetn)
        proc_reg |-> (state_reg == ST_FREE || state_reg == ST_OLD))
        else $error("read data outside sweep");

    // the newest number stays in range
    a_newest_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (newest_reg <= NUM_TOP) && (newest_reg >= NUM_NONE))
        else $error("newest number out of range");

    // no table write while a sweep reads it
    a_no_wr_in_sweep: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_FREE || state_reg == ST_OLD) |-> !tbl_wr.en)
        else $error("table write during sweep");

endmodule
